>>> rtl/icv3_pkg.sv
package icv3_pkg;

	// Field and arithmetic widths
	localparam int PIX_W    = 8;
	localparam int COEF_W   = 16;
	localparam int NUM_TAPS = 9;
	localparam int FIELDS   = 3;
	localparam int PROD_W   = PIX_W + 1 + COEF_W;
	localparam int RSUM_W   = PROD_W + 2;
	localparam int TSUM_W   = RSUM_W + 1;

	// Geometry registers
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int MAX_HEIGHT   = 4096;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_COEF_LO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_HI  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [NUM_TAPS-1:0] coef_vec_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [NUM_TAPS-1:0] pix_vec_t;

	// Which neighbors of the center pixel lie inside the frame
	typedef struct packed {
		logic row_lo;
		logic row_hi;
		logic col_lo;
		logic col_hi;
	} tap_mask_t;

endpackage

>>> rtl/icv3_lane.sv
module icv3_lane (
	input  logic                          clk,
	input  logic                          en,
	input  icv3_pkg::pix_vec_t            pix,
	input  icv3_pkg::tap_mask_t           mask,
	input  icv3_pkg::coef_vec_t           coef,
	output logic [icv3_pkg::PIX_W-1:0]    value,
	output logic                          clip
);

	localparam logic signed [icv3_pkg::TSUM_W-1:0] SUM_MIN = icv3_pkg::TSUM_W'(-255);
	localparam logic signed [icv3_pkg::TSUM_W-1:0] SUM_MAX = icv3_pkg::TSUM_W'(65535);

	logic [2:0]                             row_ok;
	logic [2:0]                             col_ok;
	icv3_pkg::pix_vec_t                     pix_m;
	logic signed [icv3_pkg::PROD_W-1:0]     prod_s3 [icv3_pkg::NUM_TAPS];
	logic signed [icv3_pkg::RSUM_W-1:0]     rsum_s4 [3];
	logic signed [icv3_pkg::TSUM_W-1:0]     sum;
	logic                                   clip_lo;
	logic                                   clip_hi;

	assign row_ok = {mask.row_hi, 1'b1, mask.row_lo};
	assign col_ok = {mask.col_hi, 1'b1, mask.col_lo};

	// Zero the taps that fall outside the frame
	always_comb begin
		for (int k = 0; k < icv3_pkg::NUM_TAPS; k++) begin
			pix_m[k] = (row_ok[k / 3] && col_ok[k % 3]) ? pix[k] : '0;
		end
	end

	// One product per tap
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < icv3_pkg::NUM_TAPS; k++) begin
				prod_s3[k] <= $signed({1'b0, pix_m[k]}) * $signed(coef[k]);
			end
		end
	end

	// Sum each kernel row
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s4[r] <= icv3_pkg::RSUM_W'(prod_s3[3*r])
					+ icv3_pkg::RSUM_W'(prod_s3[3*r+1])
					+ icv3_pkg::RSUM_W'(prod_s3[3*r+2]);
			end
		end
	end

	// Total, truncate toward zero and saturate to 0..255
	always_comb begin
		sum = icv3_pkg::TSUM_W'(rsum_s4[0]) + icv3_pkg::TSUM_W'(rsum_s4[1])
			+ icv3_pkg::TSUM_W'(rsum_s4[2]);
		clip_lo = sum < SUM_MIN;
		clip_hi = sum > SUM_MAX;
		if (clip_hi) begin
			value = '1;
		end else if (sum[icv3_pkg::TSUM_W-1]) begin
			value = '0;
		end else begin
			value = sum[2*icv3_pkg::PIX_W-1:icv3_pkg::PIX_W];
		end
		clip = clip_lo || clip_hi;
	end

endmodule

>>> rtl/image_convolution_3x3_core.sv
// The result for pixel (r,c) leaves the output register after the input word at raster
// position r*W + c + W + 1 is accepted (one row plus one pixel of lag, drained by padding words).
// One word per cycle while no skid word is held; the line memory does one read and one
// write-back per word, with the write-back forwarded when the next word reads the same column.
// Reset clears the position counters, the pipeline and output valids and loads the register
// defaults; the line memory is not cleared, its stale rows are masked by position.
module image_convolution_3x3_core #(
	parameter int MAX_WIDTH = 2048,
	parameter int CHANNELS  = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [23:0]                        s_tdata,   // sample_c0, sample_c1, sample_c2
	input  logic [0:0]                         s_tuser,   // func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // out_c0, out_c1, out_c2
	output logic [0:0]                         m_tuser,   // clipped
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [icv3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [icv3_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int NCH = (CHANNELS < icv3_pkg::FIELDS) ? CHANNELS : icv3_pkg::FIELDS;
	localparam int PXW = NCH * icv3_pkg::PIX_W;
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int AW1 = $clog2(MAX_WIDTH + 1);
	localparam int HW  = icv3_pkg::HEIGHT_REG_W;
	localparam int DW  = icv3_pkg::FIELDS * icv3_pkg::PIX_W;

	typedef struct packed {
		logic          last;
		logic          clip;
		logic [DW-1:0] data;
	} out_word_t;

	// Configuration registers
	logic [63:0]                        coef_lo_q;
	logic [63:0]                        coef_mid_q;
	logic [15:0]                        coef_hi_q;
	logic [icv3_pkg::WIDTH_REG_W-1:0]   w_reg_q;
	logic [HW-1:0]                      h_reg_q;
	logic                               cfg_wr;
	logic                               geom_wr;
	icv3_pkg::coef_vec_t                coefs;
	logic [AW1-1:0]                     w_eff;
	logic [HW-1:0]                      h_eff;

	// Position counters
	logic [AW-1:0]                      in_col_q;
	logic [HW-1:0]                      in_row_q;
	logic [AW-1:0]                      out_col_q;
	logic [HW-1:0]                      out_row_q;
	logic [AW1-1:0]                     in_col_inc;
	logic [AW1-1:0]                     out_col_inc;
	logic                               in_wrap;
	logic                               out_wrap;
	logic                               emits_now;
	logic                               fe_now;
	icv3_pkg::tap_mask_t                mask_now;

	// Handshake
	logic                               en;
	logic                               acc;
	logic                               ignore;
	logic                               take;
	logic [PXW-1:0]                     x_now;

	// Pipeline
	logic                               v_s1;
	logic                               emit_s1;
	logic                               fe_s1;
	icv3_pkg::tap_mask_t                mask_s1;
	logic [PXW-1:0]                     x_s1;
	logic [AW-1:0]                      addr_s1;
	logic [2*PXW-1:0]                   line_rd_s1;
	logic [2*PXW-1:0]                   fwd_word_s1;
	logic                               fwd_hit_s1;
	logic [PXW-1:0]                     top_cur;
	logic [PXW-1:0]                     mid_cur;
	logic                               emit_s2;
	logic                               fe_s2;
	icv3_pkg::tap_mask_t                mask_s2;
	logic                               emit_s3;
	logic                               fe_s3;
	logic                               emit_s4;
	logic                               fe_s4;

	logic [2*PXW-1:0]                   line_mem [MAX_WIDTH];
	logic [PXW-1:0]                     win_q [3][3];

	// Result and output stage
	logic [DW-1:0]                      res_data;
	logic [icv3_pkg::FIELDS-1:0]        lane_clip;
	out_word_t                          res_word;
	out_word_t                          m_word_q;
	out_word_t                          skid_word_q;
	logic                               m_valid_q;
	logic                               skid_v_q;

	// Configuration writes
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign geom_wr   = cfg_wr && (cfg_index == icv3_pkg::CFG_WIDTH
		|| cfg_index == icv3_pkg::CFG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_lo_q  <= '0;
			coef_mid_q <= 64'd256;
			coef_hi_q  <= '0;
			w_reg_q    <= 12'd640;
			h_reg_q    <= 13'd480;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				icv3_pkg::CFG_COEF_LO:  coef_lo_q  <= cfg_data;
				icv3_pkg::CFG_COEF_MID: coef_mid_q <= cfg_data;
				icv3_pkg::CFG_COEF_HI:  coef_hi_q  <= cfg_data[15:0];
				icv3_pkg::CFG_WIDTH:    w_reg_q    <= cfg_data[icv3_pkg::WIDTH_REG_W-1:0];
				icv3_pkg::CFG_HEIGHT:   h_reg_q    <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// Unpack coefficients, clamp geometry
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			coefs[k]     = coef_lo_q[icv3_pkg::COEF_W*k +: icv3_pkg::COEF_W];
			coefs[k + 4] = coef_mid_q[icv3_pkg::COEF_W*k +: icv3_pkg::COEF_W];
		end
		coefs[8] = coef_hi_q;
		if (w_reg_q == '0) begin
			w_eff = AW1'(1);
		end else if (32'(w_reg_q) > 32'(MAX_WIDTH)) begin
			w_eff = AW1'(MAX_WIDTH);
		end else begin
			w_eff = AW1'(w_reg_q);
		end
		if (h_reg_q == '0) begin
			h_eff = HW'(1);
		end else if (h_reg_q > HW'(icv3_pkg::MAX_HEIGHT)) begin
			h_eff = HW'(icv3_pkg::MAX_HEIGHT);
		end else begin
			h_eff = h_reg_q;
		end
	end

	// Accept decode and position of the result due now
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign acc      = s_tvalid && s_tready;
	assign ignore   = s_tuser[0] && in_col_q == '0 && in_row_q == '0;
	assign take     = acc && !ignore;
	assign x_now    = s_tuser[0] ? '0 : s_tdata[PXW-1:0];

	always_comb begin
		in_col_inc      = AW1'(in_col_q) + AW1'(1);
		out_col_inc     = AW1'(out_col_q) + AW1'(1);
		in_wrap         = in_col_inc >= w_eff;
		out_wrap        = out_col_inc >= w_eff;
		emits_now       = in_row_q >= HW'(2) || (in_row_q == HW'(1) && in_col_q != '0);
		fe_now          = out_row_q == h_eff - HW'(1) && out_wrap;
		mask_now.row_lo = out_row_q != '0;
		mask_now.row_hi = ({1'b0, out_row_q} + (HW+1)'(1)) < {1'b0, h_eff};
		mask_now.col_lo = out_col_q != '0;
		mask_now.col_hi = !out_wrap;
	end

	// Advance position counters; restart on geometry write or after frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (geom_wr || (take && emits_now && fe_now)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			in_col_q <= in_wrap ? '0 : AW'(in_col_inc);
			if (in_wrap) begin
				in_row_q <= in_row_q + HW'(1);
			end
			if (emits_now) begin
				out_col_q <= out_wrap ? '0 : AW'(out_col_inc);
				if (out_wrap) begin
					out_row_q <= out_row_q + HW'(1);
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			emit_s1    <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (en) begin
			v_s1    <= take;
			emit_s1 <= take && emits_now;
			if (acc) begin
				fwd_hit_s1 <= v_s1 && addr_s1 == in_col_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fe_s1       <= fe_now;
			mask_s1     <= mask_now;
			x_s1        <= x_now;
			addr_s1     <= in_col_q;
			fwd_word_s1 <= {mid_cur, x_s1};
		end
	end

	// Take the word written back this cycle if the new read hit the same column
	assign top_cur = fwd_hit_s1 ? fwd_word_s1[2*PXW-1:PXW] : line_rd_s1[2*PXW-1:PXW];
	assign mid_cur = fwd_hit_s1 ? fwd_word_s1[PXW-1:0] : line_rd_s1[PXW-1:0];

	// Line memory: read the column on accept, write back the shifted pair
	always_ff @(posedge clk) begin
		if (acc) begin
			line_rd_s1 <= line_mem[in_col_q];
		end
		if (en && v_s1) begin
			line_mem[addr_s1] <= {mid_cur, x_s1};
		end
	end

	// Shift the window by one column
	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_cur;
			win_q[1][2] <= mid_cur;
			win_q[2][2] <= x_s1;
		end
	end

	// Stages 2 to 4 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
		end else if (en) begin
			emit_s2 <= v_s1 && emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fe_s2   <= fe_s1;
			mask_s2 <= mask_s1;
			fe_s3   <= fe_s2;
			fe_s4   <= fe_s3;
		end
	end

	// One arithmetic lane per channel
	for (genvar ch = 0; ch < icv3_pkg::FIELDS; ch++) begin : g_lane
		if (ch < NCH) begin : g_on
			icv3_pkg::pix_vec_t pix;

			always_comb begin
				for (int k = 0; k < icv3_pkg::NUM_TAPS; k++) begin
					pix[k] = win_q[k / 3][k % 3][icv3_pkg::PIX_W*ch +: icv3_pkg::PIX_W];
				end
			end

			icv3_lane u_lane (
				.clk   (clk),
				.en    (en),
				.pix   (pix),
				.mask  (mask_s2),
				.coef  (coefs),
				.value (res_data[icv3_pkg::PIX_W*ch +: icv3_pkg::PIX_W]),
				.clip  (lane_clip[ch])
			);
		end else begin : g_off
			assign res_data[icv3_pkg::PIX_W*ch +: icv3_pkg::PIX_W] = '0;
			assign lane_clip[ch] = 1'b0;
		end
	end

	assign res_word.last = fe_s4;
	assign res_word.clip = |lane_clip;
	assign res_word.data = res_data;

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= skid_v_q || (en && emit_s4);
			skid_v_q  <= 1'b0;
		end else if (en && emit_s4) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_valid_q || m_tready) begin
			m_word_q <= skid_v_q ? skid_word_q : res_word;
		end else if (en && emit_s4) begin
			skid_word_q <= res_word;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_word_q.data;
	assign m_tuser[0] = m_word_q.clip;
	assign m_tlast    = m_word_q.last;

`ifndef SYNTHESIS
	// A held skid word always sits behind a presented output word
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> m_valid_q)
		else $error("skid word held with no output word presented");

	// Frame end returns every position counter to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && emits_now && fe_now) |=>
		(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("counters not restarted after frame end");

	// Input column stays inside the row
	assert property (@(posedge clk) disable iff (!arst_n) AW1'(in_col_q) < w_eff)
		else $error("input column beyond image width");

	// Results never run ahead of the input rows
	assert property (@(posedge clk) disable iff (!arst_n) out_row_q <= in_row_q)
		else $error("output row ahead of input row");
`endif

endmodule
